// ----- src/led_channel_timer_interlock_defines.svh -----
// assertion macros for the led channel timer interlock checker
`ifndef LED_CHANNEL_TIMER_INTERLOCK_DEFINES_SVH
`define LED_CHANNEL_TIMER_INTERLOCK_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LCTI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lcti check failed");

// next-cycle implication, disabled while reset is low
`define LCTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lcti check failed");

`endif

// ----- src/lcti_pkg.sv -----
// shared types, codes and constants of the led channel timer interlock
package lcti_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned CHAN_MAX     = 8;

  localparam int unsigned CH_W    = 4;
  localparam int unsigned LEVEL_W = 13;
  localparam int unsigned DUR_W   = 31;
  localparam int unsigned DELAY_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 13'd4096;

  localparam logic [LEVEL_W-1:0] UNTIMED_LIMIT_RST = 13'd1228;
  localparam logic [DELAY_W-1:0] TURN_ON_DELAY_RST = 8'd5;
  localparam logic [DUR_W-1:0]   LONG_RUN_RST      = 31'd10000000;
  localparam logic [DUR_W-1:0]   MAX_DUR_RST       = 31'd1800000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNTIMED_LIMIT = 2'd0,
    REG_TURN_ON_DELAY = 2'd1,
    REG_LONG_RUN      = 2'd2,
    REG_MAX_DURATION  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_SET_LEVEL    = 3'd0,
    OP_SWITCH       = 3'd1,
    OP_SWITCH_TIMED = 3'd2,
    OP_ALL_OFF      = 3'd3,
    OP_RESET        = 3'd4,
    OP_TICK         = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    FAULT_NONE     = 3'd0,
    FAULT_CHANNEL  = 3'd1,
    FAULT_LEVEL    = 3'd2,
    FAULT_UNTIMED  = 3'd3,
    FAULT_DURATION = 3'd4,
    FAULT_BUSY     = 3'd5,
    FAULT_LONG_RUN = 3'd6
  } fault_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHK_LVL,
    ST_DUR_MAX,
    ST_DUR_LONG,
    ST_LVL_LIM,
    ST_SUM,
    ST_END,
    ST_TICK_INC,
    ST_TICK_SCAN,
    ST_DONE
  } state_e;

  // request to the shared adder / comparator
  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  // carry is set on a subtract when a >= b
  typedef struct packed {
    logic              carry;
    logic [TIME_W-1:0] sum;
  } alu_rsp_t;

endpackage

// ----- src/lcti_alu.sv -----
// shared 32-bit adder and comparator used by the compare, sum and tick steps
module lcti_alu (
  input  lcti_pkg::alu_req_t req_i,
  output lcti_pkg::alu_rsp_t rsp_o
);
  import lcti_pkg::*;

  logic [TIME_W:0]   full;
  logic [TIME_W-1:0] b_op;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign full  = {1'b0, req_i.a} + {1'b0, b_op} + {{TIME_W{1'b0}}, req_i.sub};
  assign rsp_o = '{carry: full[TIME_W], sum: full[TIME_W-1:0]};

endmodule

// ----- src/led_channel_timer_interlock.sv -----
// led channel timer interlock: top level with command sequencer and state
//
// channel   | direction | handshake                 | contents
// s_axis    | in        | tvalid/tready             | tuser op, tdata command fields
// m_axis    | out       | tvalid/tready             | tdata enables, fault, flags
// cfg       | in        | cfg_we_i, no back-pressure | register index and value
//
// all off, reset, set level, switch off, forced switch on and decode faults go straight
// to the result; an unforced switch on adds a level check, a timed switch its limit
// compares, a sum and the end time, a tick a time increment: the single shared adder
// serves one compare or sum per cycle, and a tick walks the end times one channel a
// cycle. s_axis_tready is high only while idle. the result register lets the next command
// in while a result waits. reset clears all but the payload at once; no clearing pass.
module led_channel_timer_interlock #(
  parameter int unsigned CHANNELS = lcti_pkg::CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // channel, level, turn_on, force_req, duration_us, zero pad
  input  logic [lcti_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op
  input  logic [lcti_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // enables, fault, zero_level_warning, timers_busy, zero pad
  output logic [lcti_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [lcti_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lcti_pkg::CFG_W-1:0]       cfg_data_i
);
  import lcti_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [CH_W-1:0]  CH_TOP   = CH_W'(CHANNELS);

  state_e state_q, state_d;

  logic [LEVEL_W-1:0] limit_q;
  logic [DELAY_W-1:0] delay_q;
  logic [DUR_W-1:0]   long_q;
  logic [DUR_W-1:0]   maxdur_q;

  logic [2:0]         op_q, op_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [LEVEL_W-1:0] lvl_in_q, lvl_in_d;
  logic               on_q, on_d;
  logic               force_q, force_d;
  logic [DUR_W-1:0]   dur_q, dur_d;

  logic [CHAN_MAX-1:0] en_q, en_d;
  logic [CHAN_MAX-1:0] act_q, act_d;
  logic [TIME_W-1:0]   end_q [CHANNELS];
  logic [LEVEL_W-1:0]  lvl_q [CHANNELS];
  logic [TIME_W-1:0]   now_q, now_d;

  logic               end_we;
  logic               lvl_we;
  logic               lvl_clr;

  fault_e             fault_q, fault_d;
  logic               warn_q, warn_d;
  logic               longrun_q, longrun_d;
  logic [TIME_W-1:0]  sum_q, sum_d;
  logic [IDX_W-1:0]   scan_q, scan_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [IDX_W-1:0]   idx;
  logic [CH_W-1:0]    ch_m1;
  logic [LEVEL_W-1:0] lvl_sel;
  logic               ch_ok;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  lcti_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign ch_m1   = ch_q - CH_W'(1);
  assign idx     = ch_m1[IDX_W-1:0];
  assign lvl_sel = lvl_q[idx];
  assign ch_ok   = (ch_q != '0) && (ch_q <= CH_TOP);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= UNTIMED_LIMIT_RST;
      delay_q  <= TURN_ON_DELAY_RST;
      long_q   <= LONG_RUN_RST;
      maxdur_q <= MAX_DUR_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_UNTIMED_LIMIT: limit_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_TURN_ON_DELAY: delay_q  <= cfg_data_i[DELAY_W-1:0];
        REG_LONG_RUN:      long_q   <= cfg_data_i[DUR_W-1:0];
        REG_MAX_DURATION:  maxdur_q <= cfg_data_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= '0;
      act_q       <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      act_q       <= act_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-channel level and end time, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        end_q[i] <= '0;
        lvl_q[i] <= '0;
      end
    end else begin
      if (end_we) begin
        end_q[idx] <= alu_rsp.sum;
      end
      if (lvl_clr) begin
        for (int i = 0; i < CHANNELS; i++) begin
          lvl_q[i] <= '0;
        end
      end else if (lvl_we) begin
        lvl_q[idx] <= lvl_in_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ch_q       <= ch_d;
    lvl_in_q   <= lvl_in_d;
    on_q       <= on_d;
    force_q    <= force_d;
    dur_q      <= dur_d;
    fault_q    <= fault_d;
    warn_q     <= warn_d;
    longrun_q  <= longrun_d;
    sum_q      <= sum_d;
    scan_q     <= scan_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ch_d        = ch_q;
    lvl_in_d    = lvl_in_q;
    on_d        = on_q;
    force_d     = force_q;
    dur_d       = dur_q;
    en_d        = en_q;
    act_d       = act_q;
    now_d       = now_q;
    fault_d     = fault_q;
    warn_d      = warn_q;
    longrun_d   = longrun_q;
    sum_d       = sum_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    end_we      = 1'b0;
    lvl_we      = 1'b0;
    lvl_clr     = 1'b0;
    alu_req     = '{sub: 1'b1, a: '0, b: '0};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = s_axis_tuser;
          ch_d     = s_axis_tdata[3:0];
          lvl_in_d = s_axis_tdata[16:4];
          on_d     = s_axis_tdata[17];
          force_d  = s_axis_tdata[18];
          dur_d    = s_axis_tdata[49:19];
          fault_d  = FAULT_NONE;
          warn_d   = 1'b0;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_DONE;
        case (op_e'(op_q))
          OP_ALL_OFF: begin
            en_d  = '0;
            act_d = '0;
          end
          OP_RESET: begin
            en_d    = '0;
            act_d   = '0;
            lvl_clr = 1'b1;
          end
          OP_TICK: state_d = ST_TICK_INC;
          OP_SET_LEVEL: begin
            if (!ch_ok) begin
              fault_d = FAULT_CHANNEL;
            end else if (lvl_in_q > LEVEL_FULL) begin
              fault_d = FAULT_LEVEL;
            end else begin
              lvl_we = 1'b1;
            end
          end
          OP_SWITCH: begin
            if (!ch_ok) begin
              fault_d = FAULT_CHANNEL;
            end else if (on_q && !force_q) begin
              state_d = ST_CHK_LVL;
            end else if (on_q) begin
              en_d[idx] = 1'b1;
            end else begin
              en_d[idx]  = 1'b0;
              act_d[idx] = 1'b0;
            end
          end
          OP_SWITCH_TIMED: begin
            if (!ch_ok) begin
              fault_d = FAULT_CHANNEL;
            end else if (dur_q == '0) begin
              fault_d = FAULT_DURATION;
            end else begin
              state_d = ST_DUR_MAX;
            end
          end
          default: ;
        endcase
      end
      ST_CHK_LVL: begin
        alu_req = '{sub: 1'b1, a: TIME_W'(limit_q), b: TIME_W'(lvl_sel)};
        if (!alu_rsp.carry) begin
          fault_d = FAULT_UNTIMED;
        end else begin
          en_d[idx] = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DUR_MAX: begin
        alu_req = '{sub: 1'b1, a: TIME_W'(maxdur_q), b: TIME_W'(dur_q)};
        if (!alu_rsp.carry) begin
          fault_d = FAULT_DURATION;
          state_d = ST_DONE;
        end else if (act_q[idx]) begin
          fault_d = FAULT_BUSY;
          state_d = ST_DONE;
        end else begin
          state_d = ST_DUR_LONG;
        end
      end
      ST_DUR_LONG: begin
        alu_req   = '{sub: 1'b1, a: TIME_W'(long_q), b: TIME_W'(dur_q)};
        longrun_d = !alu_rsp.carry;
        state_d   = ST_LVL_LIM;
      end
      ST_LVL_LIM: begin
        alu_req = '{sub: 1'b1, a: TIME_W'(limit_q), b: TIME_W'(lvl_sel)};
        if (!alu_rsp.carry && longrun_q) begin
          fault_d = FAULT_LONG_RUN;
          state_d = ST_DONE;
        end else begin
          warn_d  = (lvl_sel == '0);
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        alu_req = '{sub: 1'b0, a: TIME_W'(dur_q), b: TIME_W'(delay_q)};
        sum_d   = alu_rsp.sum;
        state_d = ST_END;
      end
      ST_END: begin
        alu_req    = '{sub: 1'b0, a: now_q, b: sum_q};
        end_we     = 1'b1;
        en_d[idx]  = 1'b1;
        act_d[idx] = 1'b1;
        state_d    = ST_DONE;
      end
      ST_TICK_INC: begin
        alu_req = '{sub: 1'b0, a: now_q, b: TIME_W'(1)};
        now_d   = alu_rsp.sum;
        scan_d  = '0;
        state_d = ST_TICK_SCAN;
      end
      ST_TICK_SCAN: begin
        // timer expires once now - end is non-negative as a signed difference
        alu_req = '{sub: 1'b1, a: now_q, b: end_q[scan_q]};
        if (act_q[scan_q] && !alu_rsp.sum[TIME_W-1]) begin
          en_d[scan_q]  = 1'b0;
          act_d[scan_q] = 1'b0;
        end
        if (scan_q == LAST_IDX) begin
          state_d = ST_DONE;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, (act_q != '0), warn_q, fault_q, en_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/lcti_checker.sv -----
// port-level checks for the led channel timer interlock, bound to the top level
`include "led_channel_timer_interlock_defines.svh"

module lcti_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lcti_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import lcti_pkg::*;

  logic       s_xfer;
  logic [2:0] fault;
  logic       warn;
  logic       busy;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign fault  = m_axis_tdata[10:8];
  assign warn   = m_axis_tdata[11];
  assign busy   = m_axis_tdata[12];

  // one command at a time
  `LCTI_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_xfer, !s_axis_tready)

  // a result waiting for the sink holds
  `LCTI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

  // faults stay within the defined codes
  `LCTI_ASSERT_NOW(a_fault_code, clk_i, rst_ni, m_axis_tvalid,
                   fault <= FAULT_LONG_RUN)

  // a warning only comes with an accepted timed run, so a timer is running
  `LCTI_ASSERT_NOW(a_warn_timed, clk_i, rst_ni, m_axis_tvalid && warn,
                   busy && (fault == FAULT_NONE) && (m_axis_tdata[7:0] != 8'd0))

endmodule

bind led_channel_timer_interlock lcti_checker u_lcti_checker (.*);
